### rtl/core/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define BCT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define BCT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bct_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_W      = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command codes
  localparam logic [2:0] CMD_FIND   = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_SET    = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef enum logic [2:0] {
    OP_FIND, OP_ADD, OP_REMOVE, OP_SET, OP_CLEAR, OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [31:0]       src_ip;
    logic [31:0]       dst_ip;
    logic [15:0]       sport;
    logic [15:0]       dport;
    logic [15:0]       mport;
    logic [SLOT_W-1:0] slot;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              fwd_found;
    logic [SLOT_W-1:0] fwd_slot;
    logic              rev_found;
    logic [SLOT_W-1:0] rev_slot;
  } out_word_t;

  // classified request as held in the queue
  typedef struct packed {
    op_t               op;
    logic [31:0]       src_ip;
    logic [31:0]       dst_ip;
    logic [15:0]       sport;
    logic [15:0]       dport;
    logic [15:0]       mport;
    logic [SLOT_W-1:0] slot;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  // stored tuple and insertion stamp
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_prt;
    logic [15:0] dst_prt;
    logic [31:0] stamp;
  } entry_t;

  // slot number as reported, masked to the field width
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] ext;
    ext = (IDX_W + SLOT_W)'(idx);
    return ext[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/bidirectional_connection_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Connection tracking table of bct_pkg::TABLE_DEPTH entries. A command word is
// taken when start is high and busy is low; up to two words queue ahead of the
// execution unit. Find and set scan every entry through the table memory, one
// per cycle; set then writes the new port to the forward match, the reverse
// match or both. Add walks the valid bits up to the first free slot and reports
// full when none is free; remove, clear and unused codes finish from idle. Each
// result is shown for exactly one cycle with done high and must be taken then:
// there is no way to hold it off. Results come in command order.
module bidirectional_connection_table (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire bct_pkg::in_word_t item,
  output logic                   busy,
  output logic                   done,
  output bct_pkg::out_word_t     result
);

  bct_pkg::head_t head;
  logic           pop;

  // accept and classify
  bct_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .head  (head),
    .pop   (pop)
  );

  // execute against the table
  bct_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

`default_nettype wire

### rtl/core/bct_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/bct_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bct_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire bct_pkg::in_word_t item,
  output logic                   busy,
  output bct_pkg::head_t         head,
  input  wire logic              pop
);

  bct_pkg::job_t            q_word [bct_pkg::QUEUE_DEPTH];
  logic [bct_pkg::QPTR_W-1:0] wr_ptr;
  logic [bct_pkg::QPTR_W-1:0] rd_ptr;
  logic [bct_pkg::QCNT_W-1:0] count;
  bct_pkg::job_t            job_in;
  logic                     push;

  // classify the command word
  always_comb begin
    job_in.src_ip = item.src_ip;
    job_in.dst_ip = item.dst_ip;
    job_in.sport  = item.sport;
    job_in.dport  = item.dport;
    job_in.mport  = item.mport;
    job_in.slot   = item.slot;
    unique case (item.cmd)
      bct_pkg::CMD_FIND:   job_in.op = bct_pkg::OP_FIND;
      bct_pkg::CMD_ADD:    job_in.op = bct_pkg::OP_ADD;
      bct_pkg::CMD_REMOVE: job_in.op = bct_pkg::OP_REMOVE;
      bct_pkg::CMD_SET:    job_in.op = bct_pkg::OP_SET;
      bct_pkg::CMD_CLEAR:  job_in.op = bct_pkg::OP_CLEAR;
      default:             job_in.op = bct_pkg::OP_NOP;
    endcase
  end

  assign busy       = (count == bct_pkg::QCNT_W'(bct_pkg::QUEUE_DEPTH));
  assign push       = start && !busy;
  assign head.valid = (count != '0);
  assign head.job   = q_word[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_word[wr_ptr] <= job_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/bct_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bct_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bct_pkg::head_t head,
  output logic                pop,
  output logic                done,
  output bct_pkg::out_word_t  result
);

  localparam int DEPTH = bct_pkg::TABLE_DEPTH;
  localparam int IDX_W = bct_pkg::IDX_W;
  localparam int CNT_W = bct_pkg::CNT_W;
  localparam int SW    = bct_pkg::SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FREE, S_SETF, S_SETR
  } state_t;

  state_t           state;
  bct_pkg::job_t    job;
  logic [CNT_W-1:0] ptr;
  logic             rv;
  logic [IDX_W-1:0] rv_idx;
  logic             ffound;
  logic [IDX_W-1:0] fidx;
  logic [31:0]      fage;
  logic             rfound;
  logic [IDX_W-1:0] ridx;
  logic [31:0]      rage;
  logic [31:0]      insert_count;
  logic [DEPTH-1:0] valid;

  logic [IDX_W-1:0] ptr_idx;
  logic             ptr_in;
  logic [IDX_W-1:0] raddr;
  bct_pkg::entry_t  e_rd;
  bct_pkg::entry_t  e_wr;
  logic [15:0]      m_rd;
  logic             e_we;
  logic             m_we;
  logic [IDX_W-1:0] m_waddr;
  logic [15:0]      m_wdata;
  logic [31:0]      age;
  logic             fmatch;
  logic             rmatch;
  logic             fwin;
  logic             rwin;
  logic [IDX_W+SW-1:0] slot_ext;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_in;
  logic             rep_full;
  logic             rep_nomatch;
  logic             any_found;
  logic             pop_lookup;

  assign ptr_idx = ptr[IDX_W-1:0];
  assign ptr_in  = (ptr < CNT_W'(DEPTH));
  assign raddr   = ptr_in ? ptr_idx : '0;

  // entry write on add
  assign e_we = (state == S_FREE) && ptr_in && !valid[ptr_idx];
  always_comb begin
    e_wr.src_addr = job.src_ip;
    e_wr.dst_addr = job.dst_ip;
    e_wr.src_prt  = job.sport;
    e_wr.dst_prt  = job.dport;
    e_wr.stamp    = insert_count;
  end

  // manipulation port write on add and set
  always_comb begin
    m_we    = 1'b0;
    m_waddr = ptr_idx;
    m_wdata = job.mport;
    if (e_we) begin
      m_we = 1'b1;
    end else if (state == S_SETF) begin
      m_we    = 1'b1;
      m_waddr = fidx;
    end else if (state == S_SETR) begin
      m_we    = 1'b1;
      m_waddr = ridx;
    end
  end

  bct_ram #(.WIDTH($bits(bct_pkg::entry_t)), .DEPTH(DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (ptr_idx),
    .wdata (e_wr),
    .raddr (raddr),
    .rdata (e_rd)
  );

  bct_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_manip_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (raddr),
    .rdata (m_rd)
  );

  // match and age compare on the entry read last cycle
  always_comb begin
    age    = insert_count - e_rd.stamp;
    fmatch = rv && valid[rv_idx]
          && (e_rd.src_addr == job.src_ip) && (e_rd.dst_addr == job.dst_ip)
          && (e_rd.src_prt == job.sport) && (e_rd.dst_prt == job.dport);
    rmatch = rv && valid[rv_idx]
          && (e_rd.dst_addr == job.src_ip) && (e_rd.src_addr == job.dst_ip)
          && (e_rd.dst_prt == job.sport)
          && ((e_rd.src_prt == job.dport) || (m_rd == job.dport));
    fwin   = fmatch && (!ffound || (age < fage));
    rwin   = rmatch && (!rfound || (age < rage));
  end

  // slot range check for remove
  always_comb begin
    slot_ext = (IDX_W + SW)'(head.job.slot);
    slot_idx = slot_ext[IDX_W-1:0];
    slot_in  = ((CNT_W + SW)'(head.job.slot) < (CNT_W + SW)'(DEPTH));
  end

  assign pop = (state == S_IDLE) && head.valid;

  // sequencer
  always_ff @(posedge clk) begin : seq
    logic               done_next;
    bct_pkg::out_word_t result_next;
    done_next   = 1'b0;
    result_next = result;
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      result       <= '0;
      valid        <= '0;
      insert_count <= '0;
      ptr          <= '0;
      rv           <= 1'b0;
      ffound       <= 1'b0;
      rfound       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            job         <= head.job;
            ptr         <= '0;
            rv          <= 1'b0;
            ffound      <= 1'b0;
            rfound      <= 1'b0;
            fidx        <= '0;
            ridx        <= '0;
            result_next = '0;
            case (head.job.op) inside
              bct_pkg::OP_FIND, bct_pkg::OP_SET: state <= S_SCAN;
              bct_pkg::OP_ADD: state <= S_FREE;
              bct_pkg::OP_REMOVE: begin
                done_next = 1'b1;
                if (slot_in && valid[slot_idx]) begin
                  valid[slot_idx] <= 1'b0;
                end else begin
                  result_next.status = bct_pkg::ST_EMPTY;
                end
              end
              bct_pkg::OP_CLEAR: begin
                done_next = 1'b1;
                valid     <= '0;
              end
              default: done_next = 1'b1;
            endcase
          end
        end
        S_SCAN: begin
          if (fwin) begin
            ffound <= 1'b1;
            fidx   <= rv_idx;
            fage   <= age;
          end
          if (rwin) begin
            rfound <= 1'b1;
            ridx   <= rv_idx;
            rage   <= age;
          end
          rv     <= ptr_in;
          rv_idx <= ptr_idx;
          if (ptr_in) begin
            ptr <= ptr + 1'b1;
          end else if (!rv) begin
            result_next.fwd_found = ffound;
            result_next.fwd_slot  = ffound ? bct_pkg::to_slot(fidx) : '0;
            result_next.rev_found = rfound;
            result_next.rev_slot  = rfound ? bct_pkg::to_slot(ridx) : '0;
            if (!ffound && !rfound) begin
              result_next.status = bct_pkg::ST_NOMATCH;
              done_next          = 1'b1;
              state              <= S_IDLE;
            end else if (job.op == bct_pkg::OP_SET) begin
              state <= ffound ? S_SETF : S_SETR;
            end else begin
              done_next = 1'b1;
              state     <= S_IDLE;
            end
          end
        end
        S_FREE: begin
          if (!ptr_in) begin
            result_next.status = bct_pkg::ST_FULL;
            done_next          = 1'b1;
            state              <= S_IDLE;
          end else if (!valid[ptr_idx]) begin
            valid[ptr_idx]       <= 1'b1;
            insert_count         <= insert_count + 1'b1;
            result_next.fwd_slot = bct_pkg::to_slot(ptr_idx);
            done_next            = 1'b1;
            state                <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        S_SETF: begin
          if (rfound) begin
            state <= S_SETR;
          end else begin
            done_next = 1'b1;
            state     <= S_IDLE;
          end
        end
        S_SETR: begin
          done_next = 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      done   <= done_next;
      result <= result_next;
    end
  end

  // conditions watched by the checks
  assign rep_full    = done && (result.status == bct_pkg::ST_FULL);
  assign rep_nomatch = done && (result.status == bct_pkg::ST_NOMATCH);
  assign any_found   = result.fwd_found || result.rev_found;
  assign pop_lookup  = pop && ((head.job.op == bct_pkg::OP_FIND)
                            || (head.job.op == bct_pkg::OP_SET));

  `BCT_ASSERT_IMP(a_full_means_full, clk, rst, rep_full, &valid, "full with a free slot")
  `BCT_ASSERT_IMP(a_nomatch_clean, clk, rst, rep_nomatch, !any_found, "no match with a found flag")
  `BCT_ASSERT_IMP(a_no_write_in_scan, clk, rst, state == S_SCAN, !e_we && !m_we, "write in scan")
  `BCT_ASSERT_NXT(a_pop_starts_work, clk, rst, pop_lookup, state == S_SCAN, "lookup without scan")

endmodule

`default_nettype wire
